[hw/rtl/wcpe_pkg.sv]
// ---------------------------------------------------------------------------
// wcpe_pkg: shared definitions for the waveform column peak envelope
// Field widths, register indexes, request codes and reset values.
// ---------------------------------------------------------------------------
package wcpe_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 25;
  localparam int INDEX_W    = 10;
  localparam int FUNC_W     = 2;
  localparam int PEAK_W     = 16;
  localparam int ROW_W      = 11;

  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int GAIN_W     = 18;
  localparam int WINDOW_W   = 24;
  localparam int SCALE_W    = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SCALE   = 3'd4;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // register reset values
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 12'd256;
  localparam logic [GAIN_W-1:0]   RST_BAR_GAIN       = 18'd27525;
  localparam logic [WINDOW_W-1:0] RST_WINDOW_SAMPLES = 24'd48000;
  localparam logic [SCALE_W-1:0]  RST_COLUMN_SCALE   = 32'd357564;

  // height clamp for the span
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 12'd2048;

  typedef struct packed {
    logic [HEIGHT_W-1:0] image_height;
    logic [GAIN_W-1:0]   bar_gain;
  } span_cfg_t;

endpackage

[hw/rtl/wcpe_ram.sv]
// ---------------------------------------------------------------------------
// wcpe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module wcpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/wcpe_span.sv]
// ---------------------------------------------------------------------------
// wcpe_span: bar span of one column
// Registers peak times gain, then clamps the span around the mid row.
// ---------------------------------------------------------------------------
module wcpe_span import wcpe_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic [PEAK_W-1:0] peak,
  input  span_cfg_t         cfg,
  output logic [PEAK_W-1:0] peak_out,
  output logic [ROW_W-1:0]  bar_top,
  output logic [ROW_W-1:0]  bar_bottom
);

  localparam int PROD_W = PEAK_W + GAIN_W;

  logic [PROD_W-1:0]   prod;
  logic [PEAK_W-1:0]   peak_q;
  logic [ROW_W-1:0]    amp_raw;
  logic [ROW_W-1:0]    amp;
  logic [HEIGHT_W-1:0] h;
  logic [HEIGHT_W-1:0] h_m1;
  logic [ROW_W-1:0]    mid;
  logic [HEIGHT_W-1:0] bot_sum;
  logic [HEIGHT_W-1:0] bot;

  always_ff @(posedge clk) begin
    if (load) begin
      peak_q <= peak;
      prod   <= PROD_W'(peak) * PROD_W'(cfg.bar_gain);
    end
  end

  always_comb begin
    amp_raw = prod[PROD_W-1:23];
    amp     = (amp_raw == '0) ? ROW_W'(1) : amp_raw;
    if (cfg.image_height < HEIGHT_MIN) begin
      h = HEIGHT_MIN;
    end else if (cfg.image_height > HEIGHT_MAX) begin
      h = HEIGHT_MAX;
    end else begin
      h = cfg.image_height;
    end
    h_m1    = h - HEIGHT_W'(1);
    mid     = h[HEIGHT_W-1:1];
    bot_sum = {1'b0, mid} + {1'b0, amp};
    bot     = (bot_sum > h_m1) ? h_m1 : bot_sum;
    bar_top    = (amp < mid) ? (mid - amp) : '0;
    bar_bottom = bot[ROW_W-1:0];
    peak_out   = peak_q;
  end

endmodule

[hw/rtl/waveform_column_peak_envelope.sv]
// ---------------------------------------------------------------------------
// waveform_column_peak_envelope: per-column peak store for a waveform view
// Accumulates sample magnitudes into column peaks, reads a column's peak
// with its bar span, and clears single columns.
// ---------------------------------------------------------------------------
//
//   channel | direction | transfer when        | contents
//   --------+-----------+----------------------+------------------------------
//   s_*     | in        | s_tvalid & s_tready  | request: func, sample, position,
//           |           |                      | column index
//   m_*     | out       | m_tvalid & m_tready  | read result: peak, bar top/bottom
//   cfg_*   | in        | cfg_we               | register write, no read-back
//
// Sequencing: one request at a time, stepped by the sequencer through the
// position multiply, the RAM read and the write-back. A clear writes its
// column in ST_RD and ends there; a read passes ST_UPD and then waits in
// ST_SPAN for a free output register.
// Reset: a clearing pass writes zero to all MAX_COLUMNS entries, one a
// cycle, with s_tready low; cfg writes are taken.
// Stalls: a pending result in the output register does not block new
// requests; only the next read waits for it.
// ---------------------------------------------------------------------------
module waveform_column_peak_envelope import wcpe_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] sample_value, [40:16] sample_position, [50:41] column_index, rest zero
  input  logic [55:0]           s_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]     s_tuser,
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] column_peak, [26:16] bar_top, [37:27] bar_bottom, rest zero
  output logic [39:0]           m_tdata,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int MPOS_W = WINDOW_W;
  localparam int PROD_W = MPOS_W + SCALE_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_SPAN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [GAIN_W-1:0]   bar_gain;
  logic [WINDOW_W-1:0] window_samples;
  logic [SCALE_W-1:0]  column_scale;

  // request held for the sequence
  logic [FUNC_W-1:0]   func;
  logic [SAMPLE_W-1:0] sample;
  logic [MPOS_W-1:0]   pos;
  logic                pos_ok;
  logic [INDEX_W-1:0]  idx;
  logic [PROD_W-1:0]   product;
  logic                hit;
  logic [AW-1:0]       wb_addr;
  logic [AW-1:0]       clr_addr;

  logic                s_fire;
  logic [SAMPLE_W-1:0] in_sample;
  logic [POS_W-1:0]    in_pos;
  logic [SCALE_W-1:0]  col;
  logic                col_ok;
  logic                idx_ok;
  logic [SAMPLE_W-1:0] mag;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [PEAK_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [PEAK_W-1:0]   ram_rdata;

  logic                span_load;
  logic [PEAK_W-1:0]   span_peak;
  span_cfg_t           span_cfg;
  logic [PEAK_W-1:0]   span_peak_out;
  logic [ROW_W-1:0]    span_top;
  logic [ROW_W-1:0]    span_bottom;
  logic                m_load;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign in_sample = s_tdata[15:0];
  assign in_pos    = s_tdata[40:16];

  // column of the held position, and range checks against the width in use
  assign col    = product[PROD_W-1:24];
  assign col_ok = (col < SCALE_W'(image_width)) && (col < SCALE_W'(MAX_COLUMNS));
  assign idx_ok = ({1'b0, idx} < image_width) && (SCALE_W'(idx) < SCALE_W'(MAX_COLUMNS));
  // magnitude; the most negative sample wraps to 0x8000, which is its magnitude
  assign mag    = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

  assign m_load = (state == ST_SPAN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      bar_gain       <= RST_BAR_GAIN;
      window_samples <= RST_WINDOW_SAMPLES;
      column_scale   <= RST_COLUMN_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[HEIGHT_W-1:0];
        CFG_BAR_GAIN:       bar_gain       <= cfg_data[GAIN_W-1:0];
        CFG_WINDOW_SAMPLES: window_samples <= cfg_data[WINDOW_W-1:0];
        CFG_COLUMN_SCALE:   column_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_COLUMNS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_RD;
      ST_RD: begin
        if (func == FUNC_ACCUM || func == FUNC_READ) begin
          state_next = ST_UPD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_UPD: begin
        if (func == FUNC_READ) begin
          state_next = ST_SPAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SPAN: begin
        if (m_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // hold the request; screen the position before the multiply
  always_ff @(posedge clk) begin
    if (s_fire) begin
      func   <= s_tuser;
      sample <= in_sample;
      pos    <= in_pos[MPOS_W-1:0];
      pos_ok <= !in_pos[POS_W-1] && (in_pos[MPOS_W-1:0] <= window_samples);
      idx    <= s_tdata[50:41];
    end
    if (state == ST_MUL) begin
      product <= PROD_W'(pos) * PROD_W'(column_scale);
    end
    if (state == ST_RD) begin
      wb_addr <= AW'(col);
      hit     <= (func == FUNC_READ) ? idx_ok : (pos_ok && col_ok);
    end
  end

  // RAM access: the read is issued in ST_RD, its data used in ST_UPD
  always_comb begin
    ram_raddr = (func == FUNC_READ) ? AW'(idx) : AW'(col);
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_RD: begin
        if (func == FUNC_CLEAR && idx_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx);
        end
      end
      ST_UPD: begin
        if (func == FUNC_ACCUM && hit && (mag > ram_rdata)) begin
          ram_we    = 1'b1;
          ram_waddr = wb_addr;
          ram_wdata = mag;
        end
      end
      default: ;
    endcase
  end

  wcpe_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (MAX_COLUMNS)
  ) u_peak_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // span unit: a column out of range reads as zero peak
  assign span_load             = (state == ST_UPD) && (func == FUNC_READ);
  assign span_peak             = hit ? ram_rdata : '0;
  assign span_cfg.image_height = image_height;
  assign span_cfg.bar_gain     = bar_gain;

  wcpe_span u_span (
    .clk        (clk),
    .load       (span_load),
    .peak       (span_peak),
    .cfg        (span_cfg),
    .peak_out   (span_peak_out),
    .bar_top    (span_top),
    .bar_bottom (span_bottom)
  );

  // output register; hold the result until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= {2'b00, span_bottom, span_top, span_peak_out};
    end
  end

endmodule
